// ===== design/mxt_pkg.sv =====
// ----------------------------------------------------------------------------
// mxt_pkg
// shared constants and types for the max subarray xor trie block
// ----------------------------------------------------------------------------
package mxt_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int NODE_CAPACITY = 65536;

    localparam int IDX_W = $clog2(NODE_CAPACITY);
    localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
    localparam int LVL_W = $clog2(VALUE_BITS + 1);
    localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam int OUT_W = 32;

    typedef logic [VALUE_BITS-1:0] key_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LVL_W-1:0]      lvl_t;

    // two child pointers of one trie node, zero means no child
    typedef struct packed {
        idx_t c1;
        idx_t c0;
    } child_pair_t;

endpackage

// ===== design/mxt_in_if.sv =====
// ----------------------------------------------------------------------------
// mxt_in_if
// input channel: next element and start-of-sequence flag
// ----------------------------------------------------------------------------
interface mxt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);
endinterface

// ===== design/mxt_out_if.sv =====
// ----------------------------------------------------------------------------
// mxt_out_if
// result channel: best subarray xor so far and table-full flag
// ----------------------------------------------------------------------------
interface mxt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] best_xor;
    logic        full_res;

    modport source (output valid, output best_xor, output full_res, input ready);
    modport sink   (input valid, input best_xor, input full_res, output ready);
endinterface

// ===== design/max_subarray_xor_trie.sv =====
// ----------------------------------------------------------------------------
// max_subarray_xor_trie
// streaming maximum subarray xor using a binary trie of prefix xors held in
// a child table memory with one write port and a registered read port
//
//   channel  | dir | fields            | transfer
//   ---------+-----+-------------------+----------------------
//   in_ch    | in  | value, first      | valid && ready
//   out_ch   | out | best_xor, full_res| valid && ready
//
// an item is accepted, walks the trie on insert one level at a time, then
// allocates one new node per missing level, queries the trie level by level
// and loads the result; allocation is skipped when the new nodes do not fit,
// and when first is set prefix zero is inserted too
// the walks are bound by the child table read port, one access per level
// reset is asynchronous; the root pointers live in flops and are cleared at
// reset and on first, so the memory needs no clearing pass
// input is taken only between items; a result waits in the output register
// and a stalled result holds the next item at its final step
// ----------------------------------------------------------------------------
module max_subarray_xor_trie (
    input  logic      clk,
    input  logic      rst_n,
    mxt_in_if.sink    in_ch,
    mxt_out_if.source out_ch
);
    import mxt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_QUERY,
        ST_DONE
    } state_t;

    state_t      state_reg;
    child_pair_t root_reg;
    child_pair_t mem_q_reg;
    child_pair_t ent_reg;
    cnt_t        node_count_reg;
    key_t        prefix_reg;
    key_t        key_reg;
    key_t        acc_reg;
    key_t        best_so_far_reg;
    logic        overflowed_reg;
    logic        pending_reg;
    idx_t        cur_reg;
    lvl_t        lvl_reg;
    logic        out_valid_reg;
    logic [OUT_W-1:0] out_best_reg;
    logic        out_full_reg;

    child_pair_t child_table [NODE_CAPACITY];

    child_pair_t entry;
    lvl_t        lvl_m1;
    logic        kbit;
    idx_t        same_child;
    idx_t        other_child;
    cnt_t        free_nodes;
    logic        fits;
    idx_t        cur_next;
    idx_t        new_idx;
    child_pair_t linked_ent;
    logic        wr_mem;
    child_pair_t wr_data;
    logic        in_xfer;
    logic        out_load;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.best_xor = out_best_reg;
    assign out_ch.full_res = out_full_reg;

    always_comb
    begin
        entry       = (cur_reg == '0) ? root_reg : mem_q_reg;
        lvl_m1      = lvl_reg - lvl_t'(1);
        kbit        = key_reg[lvl_m1[BIT_W-1:0]];
        same_child  = kbit ? entry.c1 : entry.c0;
        other_child = kbit ? entry.c0 : entry.c1;
        free_nodes  = cnt_t'(NODE_CAPACITY) - node_count_reg;
        fits        = cnt_t'(lvl_reg) <= free_nodes;
        new_idx     = node_count_reg[IDX_W-1:0];
        linked_ent  = ent_reg;
        if (kbit)
        begin
            linked_ent.c1 = new_idx;
        end
        else
        begin
            linked_ent.c0 = new_idx;
        end

        cur_next = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cur_next = '0;
            end
            ST_WALK:
            begin
                if (lvl_reg != '0 && same_child != '0)
                begin
                    cur_next = same_child;
                end
                else if (lvl_reg != '0 && fits)
                begin
                    cur_next = cur_reg;
                end
                else
                begin
                    cur_next = '0;
                end
            end
            ST_ALLOC:
            begin
                if (lvl_reg != '0)
                begin
                    cur_next = new_idx;
                end
                else
                begin
                    cur_next = '0;
                end
            end
            ST_QUERY:
            begin
                if (lvl_reg != '0 && other_child != '0)
                begin
                    cur_next = other_child;
                end
                else if (lvl_reg != '0 && same_child != '0)
                begin
                    cur_next = same_child;
                end
                else
                begin
                    cur_next = '0;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase

        wr_mem  = (state_reg == ST_ALLOC) && (cur_reg != '0);
        wr_data = (lvl_reg != '0) ? linked_ent : ent_reg;
    end

    // child table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_mem)
        begin
            child_table[cur_reg] <= wr_data;
        end
        mem_q_reg <= child_table[cur_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            root_reg        <= '0;
            ent_reg         <= '0;
            node_count_reg  <= cnt_t'(1);
            prefix_reg      <= '0;
            key_reg         <= '0;
            acc_reg         <= '0;
            best_so_far_reg <= '0;
            overflowed_reg  <= 1'b0;
            pending_reg     <= 1'b0;
            cur_reg         <= '0;
            lvl_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_best_reg    <= '0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            cur_reg <= cur_next;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        lvl_reg <= lvl_t'(VALUE_BITS);
                        state_reg <= ST_WALK;
                        if (in_ch.first)
                        begin
                            root_reg        <= '0;
                            node_count_reg  <= cnt_t'(1);
                            best_so_far_reg <= '0;
                            overflowed_reg  <= 1'b0;
                            prefix_reg      <= key_t'(in_ch.value);
                            key_reg         <= '0;
                            pending_reg     <= 1'b1;
                        end
                        else
                        begin
                            prefix_reg  <= prefix_reg ^ key_t'(in_ch.value);
                            key_reg     <= prefix_reg ^ key_t'(in_ch.value);
                            pending_reg <= 1'b0;
                        end
                    end
                end
                ST_WALK:
                begin
                    if (lvl_reg != '0 && same_child != '0)
                    begin
                        lvl_reg <= lvl_m1;
                    end
                    else if (lvl_reg != '0 && fits)
                    begin
                        ent_reg   <= entry;
                        state_reg <= ST_ALLOC;
                    end
                    else
                    begin
                        if (lvl_reg != '0)
                        begin
                            overflowed_reg <= 1'b1;
                        end
                        lvl_reg <= lvl_t'(VALUE_BITS);
                        if (pending_reg)
                        begin
                            pending_reg <= 1'b0;
                            key_reg     <= prefix_reg;
                        end
                        else
                        begin
                            acc_reg   <= '0;
                            state_reg <= ST_QUERY;
                        end
                    end
                end
                ST_ALLOC:
                begin
                    if (lvl_reg != '0)
                    begin
                        if (cur_reg == '0)
                        begin
                            root_reg <= linked_ent;
                        end
                        ent_reg        <= '0;
                        node_count_reg <= node_count_reg + cnt_t'(1);
                        lvl_reg        <= lvl_m1;
                    end
                    else
                    begin
                        lvl_reg <= lvl_t'(VALUE_BITS);
                        if (pending_reg)
                        begin
                            pending_reg <= 1'b0;
                            key_reg     <= prefix_reg;
                            state_reg   <= ST_WALK;
                        end
                        else
                        begin
                            acc_reg   <= '0;
                            state_reg <= ST_QUERY;
                        end
                    end
                end
                ST_QUERY:
                begin
                    if (lvl_reg != '0 && other_child != '0)
                    begin
                        acc_reg <= acc_reg | (key_t'(1) << lvl_m1[BIT_W-1:0]);
                        lvl_reg <= lvl_m1;
                    end
                    else if (lvl_reg != '0 && same_child != '0)
                    begin
                        lvl_reg <= lvl_m1;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        if (acc_reg > best_so_far_reg)
                        begin
                            best_so_far_reg <= acc_reg;
                            out_best_reg    <= acc_reg[OUT_W-1:0];
                        end
                        else
                        begin
                            out_best_reg <= best_so_far_reg[OUT_W-1:0];
                        end
                        out_full_reg  <= overflowed_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // node count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (node_count_reg >= cnt_t'(1)) && (node_count_reg <= cnt_t'(NODE_CAPACITY)))
        else $error("node count out of range");

    // a start transfer empties the trie
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ch.first) |=> (node_count_reg == cnt_t'(1)) && (root_reg == '0))
        else $error("trie not emptied on start");

    // running best never falls when a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (best_so_far_reg >= $past(best_so_far_reg)))
        else $error("running best decreased");

    // a new result is loaded only when the output register is free or drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready && state_reg == ST_DONE) |=> state_reg == ST_DONE)
        else $error("result overwritten while stalled");

endmodule

// ===== tb/tb_max_subarray_xor_trie.sv =====
// ----------------------------------------------------------------------------
// tb_max_subarray_xor_trie
// self-checking testbench for the max subarray xor trie block
//
// items go in through the input channel. On every input transfer a trie
// predictor, kept inside the testbench, works out the expected best xor and
// table-full flag. Each result transfer is checked against the oldest
// expectation. Both channels idle in random bursts, but not in the final
// random tail. The receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_max_subarray_xor_trie;
    import mxt_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [31:0] best_xor;
        logic        full_res;
    } result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mxt_in_if  in_ch ();
    mxt_out_if out_ch ();

    max_subarray_xor_trie DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // trie predictor state
    bit [IDX_W-1:0] kids [NODE_CAPACITY][2];
    int             used_nodes = 1;
    key_t           run_prefix = '0;
    key_t           run_best   = '0;
    bit             table_full = 1'b0;

    result_t expected_best [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    int      rx_hold = 0;
    int      rx_stall = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void trie_add(input key_t key);
        int       cur;
        int       lvl;
        int       n;
        bit [IDX_W-1:0] nxt;
        cur = 0;
        lvl = VALUE_BITS;
        while (lvl > 0) begin
            nxt = kids[cur][key[lvl-1]];
            if (nxt == 0)
                break;
            cur = int'(nxt);
            lvl--;
        end
        if (lvl > NODE_CAPACITY - used_nodes) begin
            table_full = 1'b1;
            return;
        end
        while (lvl > 0) begin
            n = used_nodes;
            used_nodes++;
            kids[n][0] = '0;
            kids[n][1] = '0;
            kids[cur][key[lvl-1]] = n[IDX_W-1:0];
            cur = n;
            lvl--;
        end
    endfunction

    function automatic key_t trie_max_xor(input key_t key);
        int       cur;
        key_t     acc;
        bit       b;
        bit [IDX_W-1:0] other;
        bit [IDX_W-1:0] same;
        cur = 0;
        acc = '0;
        for (int lvl = VALUE_BITS; lvl > 0; lvl--) begin
            b     = key[lvl-1];
            other = kids[cur][b ^ 1'b1];
            same  = kids[cur][b];
            if (other != 0) begin
                acc[lvl-1] = 1'b1;
                cur = int'(other);
            end
            else if (same != 0)
                cur = int'(same);
            else
                break;
        end
        return acc;
    endfunction

    function automatic void predict_best_xor(input logic [31:0] value, input logic first);
        key_t    cand;
        result_t item;
        if (first) begin
            used_nodes = 1;
            kids[0][0] = '0;
            kids[0][1] = '0;
            run_prefix = '0;
            run_best   = '0;
            table_full = 1'b0;
            trie_add('0);
        end
        run_prefix = run_prefix ^ key_t'(value);
        trie_add(run_prefix);
        cand = trie_max_xor(run_prefix);
        if (cand > run_best)
            run_best = cand;
        item.best_xor = run_best[31:0];
        item.full_res = table_full;
        expected_best = {expected_best, item};
    endfunction

    function automatic logic [31:0] pick_value(input logic [31:0] last);
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            5:       return $urandom_range(0, 255);
            6:       return 32'h1 << $urandom_range(0, 31);
            7:       return ~(32'h1 << $urandom_range(0, 31));
            8:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            9:       return last;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_element(input logic [31:0] value, input logic first);
        int gap;
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.first <= first;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_best_xor(value, first);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_best.size() != 0)
            @(posedge clk);
    endtask

    // items before any start flag run on the bare reset trie
    task automatic test_no_start_after_reset;
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h0000_0001, 1'b0);
        send_element($urandom, 1'b0);
    endtask

    task automatic test_directed_values;
        send_element(32'h0000_0000, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b1);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h0000_0001, 1'b0);
        send_element(32'hAAAA_AAAA, 1'b0);
        send_element(32'h5555_5555, 1'b0);
        send_element(32'h1234_5678, 1'b1);
        send_element(32'h1234_5678, 1'b0);
        send_element(32'h1234_5678, 1'b0);
        send_element(32'h8000_0000, 1'b1);
        send_element(32'h8000_0000, 1'b1);
        send_element(32'h0000_0001, 1'b0);
        send_element(32'hFFFF_FFFE, 1'b0);
        send_element(32'h0F0F_0F0F, 1'b0);
        send_element(32'hF0F0_F0F0, 1'b0);
        wait_drained();
    endtask

    task automatic run_random_items(input int count);
        int          sent;
        int          len;
        logic [31:0] value;
        logic        starts;
        sent  = 0;
        value = '0;
        while (sent < count) begin
            len    = $urandom_range(1, 40);
            // a few sequences carry on from the previous one without a start
            starts = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len && sent < count; i++) begin
                value = pick_value(value);
                send_element(value, (i == 0) ? starts : ($urandom_range(0, 99) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_random_sequences;
        run_random_items(1300);
        wait_drained();
    endtask

    task automatic test_output_hold;
        rx_hold = 600;
        send_element($urandom, 1'b1);
        for (int i = 0; i < 7; i++)
            send_element($urandom, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_tail;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_items(250);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.first = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_no_start_after_reset();
        test_directed_values();
        test_random_sequences();
        test_output_hold();
        test_random_tail();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_best.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver side
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_stall > 0) begin
                out_ch.ready <= 1'b0;
                rx_stall--;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                rx_stall = $urandom_range(1, 18) - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_best.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: best_xor=%h full_res=%b",
                             out_ch.best_xor, out_ch.full_res);
            end
            else begin
                want = expected_best.pop_front();
                if (want.best_xor !== out_ch.best_xor || want.full_res !== out_ch.full_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: best_xor exp %h got %h, full_res exp %b got %b",
                                 want.best_xor, out_ch.best_xor, want.full_res,
                                 out_ch.full_res);
                end
            end
        end
    end

    // no transfer on either channel for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
